@@ rtl/fomdq_pkg.sv @@
// Package for the FIFO / max-weight dispatch queue: sizes, codes, beat and cell types.
// Used by every module in rtl/; depends on nothing.
package fomdq_pkg;

   localparam int DEPTH       = 64;
   localparam int WEIGHT_BITS = 20;
   localparam int ID_BITS     = 32;
   localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_BITS    = $clog2(DEPTH + 1);

   // command codes; any code with the high bit set means serve largest
   localparam logic [1:0] CMD_ARRIVE = 2'd0;
   localparam logic [1:0] CMD_OLDEST = 2'd1;

   // status codes
   localparam logic [1:0] STATUS_STORED = 2'd0;
   localparam logic [1:0] STATUS_SERVED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]             cmd;
      logic [WEIGHT_BITS-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] served_id;
      logic [1:0]         status;
   } rsp_type;

   // one stored entry, as a cell shows it to its lower neighbor
   typedef struct packed {
      logic                   valid;
      logic [ID_BITS-1:0]     id;
      logic [WEIGHT_BITS-1:0] weight;
   } entry_type;

   // running best candidate of the search wave
   typedef struct packed {
      logic                   vld;
      logic                   has;
      logic [IDX_BITS-1:0]    idx;
      logic [ID_BITS-1:0]     id;
      logic [WEIGHT_BITS-1:0] weight;
   } wave_type;

   // broadcast control from the sequencer to all cells
   typedef struct packed {
      logic                   load;
      logic                   remove;
      logic                   wave_start;
      logic [IDX_BITS-1:0]    pos;
      logic [ID_BITS-1:0]     new_id;
      logic [WEIGHT_BITS-1:0] new_weight;
   } cell_ctl_type;

endpackage

@@ rtl/fomdq_cell.sv @@
// One queue cell: holds one entry, compacts from its upper neighbor, and forwards
// the max-weight search wave to the next cell. Depends on fomdq_pkg.
module fomdq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [fomdq_pkg::IDX_BITS-1:0] cell_idx,
   input  fomdq_pkg::cell_ctl_type ctl,
   input  fomdq_pkg::entry_type    upper_ent,
   output fomdq_pkg::entry_type    ent,
   input  fomdq_pkg::wave_type     wave_prev,
   output fomdq_pkg::wave_type     wave
);

   logic                                ent_valid_ff, ent_valid_in;
   logic [fomdq_pkg::ID_BITS-1:0]       ent_id_ff, ent_id_in;
   logic [fomdq_pkg::WEIGHT_BITS-1:0]   ent_w_ff, ent_w_in;

   logic                                wave_vld_ff;
   logic                                wave_has_ff, wave_has_in;
   logic [fomdq_pkg::IDX_BITS-1:0]      wave_idx_ff, wave_idx_in;
   logic [fomdq_pkg::ID_BITS-1:0]       wave_id_ff, wave_id_in;
   logic [fomdq_pkg::WEIGHT_BITS-1:0]   wave_w_ff, wave_w_in;
   logic                                take_own;

   // load a new arrival here, or shift down from the upper neighbor
   always_comb begin
      ent_valid_in = ent_valid_ff;
      ent_id_in    = ent_id_ff;
      ent_w_in     = ent_w_ff;
      if (ctl.load && (cell_idx == ctl.pos)) begin
         ent_valid_in = 1'b1;
         ent_id_in    = ctl.new_id;
         ent_w_in     = ctl.new_weight;
      end else if (ctl.remove && (cell_idx >= ctl.pos)) begin
         ent_valid_in = upper_ent.valid;
         ent_id_in    = upper_ent.id;
         ent_w_in     = upper_ent.weight;
      end
   end

   // replace the candidate only on a strictly larger weight: earlier wins ties
   assign take_own = ent_valid_ff && (!wave_prev.has || (ent_w_ff > wave_prev.weight));

   always_comb begin
      wave_has_in = wave_has_ff;
      wave_idx_in = wave_idx_ff;
      wave_id_in  = wave_id_ff;
      wave_w_in   = wave_w_ff;
      if (wave_prev.vld) begin
         if (take_own) begin
            wave_has_in = 1'b1;
            wave_idx_in = cell_idx;
            wave_id_in  = ent_id_ff;
            wave_w_in   = ent_w_ff;
         end else begin
            wave_has_in = wave_prev.has;
            wave_idx_in = wave_prev.idx;
            wave_id_in  = wave_prev.id;
            wave_w_in   = wave_prev.weight;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
         wave_vld_ff  <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
         wave_vld_ff  <= wave_prev.vld;
      end
   end

   always_ff @(posedge clock) begin
      ent_id_ff   <= ent_id_in;
      ent_w_ff    <= ent_w_in;
      wave_has_ff <= wave_has_in;
      wave_idx_ff <= wave_idx_in;
      wave_id_ff  <= wave_id_in;
      wave_w_ff   <= wave_w_in;
   end

   assign ent.valid   = ent_valid_ff;
   assign ent.id      = ent_id_ff;
   assign ent.weight  = ent_w_ff;

   assign wave.vld    = wave_vld_ff;
   assign wave.has    = wave_has_ff;
   assign wave.idx    = wave_idx_ff;
   assign wave.id     = wave_id_ff;
   assign wave.weight = wave_w_ff;

endmodule

@@ rtl/fifo_or_max_dispatch_queue_core.sv @@
// Top level of the dispatch queue: sequencer, counters, output register and cell row.
// Depends on fomdq_pkg and fomdq_cell.
//
//   channel | dir | handshake           | beat
//   req     | in  | req_valid/req_stall | fomdq_pkg::req_type {cmd, weight}
//   rsp     | out | rsp_valid/rsp_stall | fomdq_pkg::rsp_type {served_id, status}
//
// Arrive (also on a full queue), serve oldest, and a serve on an empty queue finish in
// the execute step. Serve largest on a non-empty queue starts the compare wave there; the
// wave walks the cell row one cell per cycle, then the finish step compacts the row.
// Reset is synchronous and empties the queue; ids restart at 1.
// A new beat is taken while the previous result still waits in the output register;
// the block holds in its execute or finish step while that result is stalled.
module fifo_or_max_dispatch_queue_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fomdq_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output fomdq_pkg::rsp_type rsp_data
);

   fomdq_pkg::state_type              state_ff, state_in;
   logic [1:0]                        cmd_ff;
   logic [fomdq_pkg::WEIGHT_BITS-1:0] weight_ff;
   logic [fomdq_pkg::OCC_BITS-1:0]    occ_ff, occ_in;
   logic [fomdq_pkg::ID_BITS-1:0]     next_id_ff, next_id_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   fomdq_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic                              rsp_load;

   logic                              out_free;
   logic                              is_arrive;
   logic                              is_oldest;
   logic                              q_empty;
   logic                              q_full;

   fomdq_pkg::cell_ctl_type           ctl;
   fomdq_pkg::entry_type              ent_q  [fomdq_pkg::DEPTH];
   fomdq_pkg::wave_type               wave_q [fomdq_pkg::DEPTH];
   fomdq_pkg::wave_type               wave_head;
   fomdq_pkg::wave_type               wave_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_arrive = (cmd_ff == fomdq_pkg::CMD_ARRIVE);
   assign is_oldest = (cmd_ff == fomdq_pkg::CMD_OLDEST);
   assign q_empty   = (occ_ff == '0);
   assign q_full    = (occ_ff == fomdq_pkg::OCC_BITS'(fomdq_pkg::DEPTH));
   assign wave_last = wave_q[fomdq_pkg::DEPTH-1];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fomdq_pkg::ST_IDLE: begin
            if (req_valid) state_in = fomdq_pkg::ST_EXEC;
         end
         fomdq_pkg::ST_EXEC: begin
            if (!is_arrive && !is_oldest && !q_empty) state_in = fomdq_pkg::ST_SEARCH;
            else if (out_free) state_in = fomdq_pkg::ST_IDLE;
         end
         fomdq_pkg::ST_SEARCH: begin
            if (wave_last.vld) state_in = fomdq_pkg::ST_FINISH;
         end
         fomdq_pkg::ST_FINISH: begin
            if (out_free) state_in = fomdq_pkg::ST_IDLE;
         end
         default: state_in = fomdq_pkg::ST_IDLE;
      endcase
   end

   // cell control, counters and result
   always_comb begin
      ctl                   = '0;
      occ_in                = occ_ff;
      next_id_in            = next_id_ff;
      rsp_load              = 1'b0;
      rsp_data_in.served_id = '0;
      rsp_data_in.status    = fomdq_pkg::STATUS_EMPTY;
      case (state_ff)
         fomdq_pkg::ST_EXEC: begin
            if (is_arrive) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  if (q_full) begin
                     rsp_data_in.status = fomdq_pkg::STATUS_FULL;
                  end else begin
                     ctl.load              = 1'b1;
                     ctl.pos               = occ_ff[fomdq_pkg::IDX_BITS-1:0];
                     ctl.new_id            = next_id_ff + 32'd1;
                     ctl.new_weight        = weight_ff;
                     next_id_in            = next_id_ff + 32'd1;
                     occ_in                = occ_ff + fomdq_pkg::OCC_BITS'(1);
                     rsp_data_in.served_id = next_id_ff + 32'd1;
                     rsp_data_in.status    = fomdq_pkg::STATUS_STORED;
                  end
               end
            end else if (q_empty) begin
               if (out_free) begin
                  rsp_load = 1'b1;
               end
            end else if (is_oldest) begin
               if (out_free) begin
                  rsp_load              = 1'b1;
                  ctl.remove            = 1'b1;
                  ctl.pos               = '0;
                  occ_in                = occ_ff - fomdq_pkg::OCC_BITS'(1);
                  rsp_data_in.served_id = ent_q[0].id;
                  rsp_data_in.status    = fomdq_pkg::STATUS_SERVED;
               end
            end else begin
               ctl.wave_start = 1'b1;
            end
         end
         fomdq_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_load              = 1'b1;
               ctl.remove            = 1'b1;
               ctl.pos               = wave_last.idx;
               occ_in                = occ_ff - fomdq_pkg::OCC_BITS'(1);
               rsp_data_in.served_id = wave_last.id;
               rsp_data_in.status    = fomdq_pkg::STATUS_SERVED;
            end
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // hold the result until taken
   always_comb begin
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fomdq_pkg::ST_IDLE;
         occ_ff       <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the accepted beat
   always_ff @(posedge clock) begin
      if ((state_ff == fomdq_pkg::ST_IDLE) && req_valid) begin
         cmd_ff    <= req_data.cmd;
         weight_ff <= req_data.weight;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // wave enters cell 0 with no candidate yet
   always_comb begin
      wave_head     = '0;
      wave_head.vld = ctl.wave_start;
   end

   // row of cells, cell 0 holds the oldest entry
   for (genvar i = 0; i < fomdq_pkg::DEPTH; i++) begin : g_cell
      fomdq_pkg::entry_type upper;
      fomdq_pkg::wave_type  prev;
      if (i == fomdq_pkg::DEPTH - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = ent_q[i+1];
      end
      if (i == 0) begin : g_first
         assign prev = wave_head;
      end else begin : g_next
         assign prev = wave_q[i-1];
      end
      fomdq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (fomdq_pkg::IDX_BITS'(i)),
         .ctl       (ctl),
         .upper_ent (upper),
         .ent       (ent_q[i]),
         .wave_prev (prev),
         .wave      (wave_q[i])
      );
   end

   assign req_stall = (state_ff != fomdq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/fomdq_checker.sv @@
// Port-level checks for the dispatch queue, bound to the top level.
// Depends on fomdq_pkg and fifo_or_max_dispatch_queue_core.
module fomdq_port_checks (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input fomdq_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input fomdq_pkg::rsp_type rsp_data
);

   logic [1:0] pend_ff, pend_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // count beats taken but not yet answered
   always_comb begin
      pend_in = pend_ff;
      if (req_beat && !rsp_beat) pend_in = pend_ff + 2'd1;
      else if (!req_beat && rsp_beat) pend_in = pend_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else pend_ff <= pend_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result beat without a pending request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 2'd2)
      else $error("more than two requests in flight");

   a_reject_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == fomdq_pkg::STATUS_EMPTY ||
                    rsp_data.status == fomdq_pkg::STATUS_FULL)
      |-> rsp_data.served_id == '0)
      else $error("empty or full result carries an id");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind fifo_or_max_dispatch_queue_core fomdq_port_checks u_fomdq_port_checks (.*);

@@ dv/fomdq_checker.sv @@
// Scoreboard for the dispatch queue: mirrors the queue contents, predicts each result beat
// and compares it with the block's output. Depends on fomdq_pkg only.
`timescale 1ns / 1ps

module fomdq_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  fomdq_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  fomdq_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 pending,
   output int                 req_beats,
   output int                 stored_seen,
   output int                 served_seen,
   output int                 empty_seen,
   output int                 full_seen,
   output int                 peak_depth
);

   // mirror of the queue: cell 0 holds the oldest entry
   logic [fomdq_pkg::ID_BITS-1:0]     cell_id     [fomdq_pkg::DEPTH];
   logic [fomdq_pkg::WEIGHT_BITS-1:0] cell_weight [fomdq_pkg::DEPTH];
   int unsigned                       cell_count = 0;
   logic [fomdq_pkg::ID_BITS-1:0]     last_id = '0;

   fomdq_pkg::rsp_type expected_q [$];
   fomdq_pkg::rsp_type want;
   fomdq_pkg::rsp_type next_want;
   int      mismatches = 0;
   int      n_req      = 0;
   int      n_stored   = 0;
   int      n_served   = 0;
   int      n_empty    = 0;
   int      n_full     = 0;
   int      n_peak     = 0;

   // apply one request beat to the mirror and return the result it should produce
   function automatic fomdq_pkg::rsp_type dispatch_step(fomdq_pkg::req_type beat);
      fomdq_pkg::rsp_type res;
      int unsigned        pos;
      res.served_id = '0;
      res.status    = fomdq_pkg::STATUS_EMPTY;
      if (beat.cmd == fomdq_pkg::CMD_ARRIVE) begin
         if (cell_count >= fomdq_pkg::DEPTH) begin
            // no room: drop it and keep the id counter
            res.status = fomdq_pkg::STATUS_FULL;
         end else begin
            last_id                 = last_id + 1'b1;
            cell_id[cell_count]     = last_id;
            cell_weight[cell_count] = beat.weight;
            cell_count++;
            res.served_id = last_id;
            res.status    = fomdq_pkg::STATUS_STORED;
         end
      end else if (cell_count != 0) begin
         // serve oldest takes cell 0; serve largest takes the first cell of greatest weight
         pos = 0;
         if (beat.cmd != fomdq_pkg::CMD_OLDEST) begin
            for (int unsigned i = 1; i < cell_count; i++) begin
               if (cell_weight[i] > cell_weight[pos]) pos = i;
            end
         end
         res.served_id = cell_id[pos];
         res.status    = fomdq_pkg::STATUS_SERVED;
         // compact the later cells down by one
         for (int unsigned i = pos; i + 1 < cell_count; i++) begin
            cell_id[i]     = cell_id[i + 1];
            cell_weight[i] = cell_weight[i + 1];
         end
         cell_count--;
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what, input fomdq_pkg::rsp_type exp_beat,
                                input fomdq_pkg::rsp_type got_beat);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t ns: %s: expected id %0d status %0d, got id %0d status %0d",
                  $time, what, exp_beat.served_id, exp_beat.status,
                  got_beat.served_id, got_beat.status);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cell_count = 0;
         last_id    = '0;
         expected_q.delete();
      end else begin
         // check the result beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               note_mismatch("result with nothing expected", '0, rsp_data);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.served_id !== want.served_id || rsp_data.status !== want.status) begin
                  note_mismatch("result mismatch", want, rsp_data);
               end
               case (want.status)
                  fomdq_pkg::STATUS_STORED: n_stored++;
                  fomdq_pkg::STATUS_SERVED: n_served++;
                  fomdq_pkg::STATUS_EMPTY:  n_empty++;
                  default:                  n_full++;
               endcase
            end
         end
         // predict the result of an accepted request beat and queue it at the tail
         if (req_valid && !req_stall) begin
            next_want  = dispatch_step(req_data);
            expected_q = {expected_q, next_want};
            n_req++;
            if (cell_count > n_peak) n_peak = cell_count;
         end
      end
      fail_count  <= mismatches;
      pending     <= expected_q.size();
      req_beats   <= n_req;
      stored_seen <= n_stored;
      served_seen <= n_served;
      empty_seen  <= n_empty;
      full_seen   <= n_full;
      peak_depth  <= n_peak;
   end

endmodule

@@ dv/tb_fifo_or_max_dispatch_queue_core.sv @@
// Testbench top for the dispatch queue: clock, reset, request stimulus, result back-pressure,
// watchdog and verdict. Depends on fomdq_pkg, fomdq_checker and the core.
`timescale 1ns / 1ps

module tb_fifo_or_max_dispatch_queue_core;

   // serve largest is decoded by the high bit, so both codes reach it
   localparam logic [1:0] CMD_LARGEST     = 2'd2;
   localparam logic [1:0] CMD_LARGEST_ALT = 2'd3;

   localparam int RANDOM_ITEMS  = 1450;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 150;
   localparam logic [fomdq_pkg::WEIGHT_BITS-1:0] WEIGHT_MAX = '1;

   typedef enum int {
      BURST_FILL,
      BURST_DRAIN,
      BURST_EVEN
   } burst_mode_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   fomdq_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   fomdq_pkg::rsp_type rsp_data;

   int fail_count;
   int pending;
   int req_beats;
   int stored_seen;
   int served_seen;
   int empty_seen;
   int full_seen;
   int peak_depth;

   int send_idle_pct;
   int recv_stall_pct;
   logic hold_req;

   fifo_or_max_dispatch_queue_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   fomdq_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .req_beats   (req_beats),
      .stored_seen (stored_seen),
      .served_seen (served_seen),
      .empty_seen  (empty_seen),
      .full_seen   (full_seen),
      .peak_depth  (peak_depth)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // weights lean on the extremes and on a narrow range so ties are common
   function automatic logic [fomdq_pkg::WEIGHT_BITS-1:0] pick_weight();
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return WEIGHT_MAX;
      if (r <= 4) return fomdq_pkg::WEIGHT_BITS'($urandom_range(7));
      return fomdq_pkg::WEIGHT_BITS'($urandom());
   endfunction

   // offer one request beat after a random idle gap; return at the edge that accepts it
   task automatic send_beat(input logic [1:0] cmd,
                            input logic [fomdq_pkg::WEIGHT_BITS-1:0] weight);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data.cmd    <= cmd;
      req_data.weight <= weight;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   // result side: random stall, plus one long hold-off to back the queue up
   initial begin : receiver
      int hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // end the run if nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      burst_mode_type mode;
      int             burst_left;
      int             arrive_pct;
      int unsigned    pick;
      logic [1:0]     cmd;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      send_idle_pct  = 34;
      recv_stall_pct = 72;
      hold_req       = 1'b0;
      burst_left     = 0;
      mode           = BURST_EVEN;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // serves on an empty queue, every serve code
      send_beat(fomdq_pkg::CMD_OLDEST, pick_weight());
      send_beat(CMD_LARGEST, pick_weight());
      send_beat(CMD_LARGEST_ALT, pick_weight());
      // extreme weights and a tie on the maximum
      send_beat(fomdq_pkg::CMD_ARRIVE, '0);
      send_beat(fomdq_pkg::CMD_ARRIVE, WEIGHT_MAX);
      send_beat(fomdq_pkg::CMD_ARRIVE, 20'd5);
      send_beat(fomdq_pkg::CMD_ARRIVE, WEIGHT_MAX);
      send_beat(fomdq_pkg::CMD_ARRIVE, '0);
      send_beat(CMD_LARGEST, pick_weight());
      send_beat(CMD_LARGEST_ALT, pick_weight());
      send_beat(fomdq_pkg::CMD_OLDEST, pick_weight());
      // three-way tie on a small weight
      send_beat(fomdq_pkg::CMD_ARRIVE, 20'd7);
      send_beat(fomdq_pkg::CMD_ARRIVE, 20'd7);
      send_beat(fomdq_pkg::CMD_ARRIVE, 20'd7);
      send_beat(CMD_LARGEST, pick_weight());
      send_beat(fomdq_pkg::CMD_OLDEST, pick_weight());
      send_beat(CMD_LARGEST_ALT, pick_weight());
      // drain what is left, then two more serves on empty
      send_beat(CMD_LARGEST, pick_weight());
      send_beat(fomdq_pkg::CMD_OLDEST, pick_weight());
      send_beat(fomdq_pkg::CMD_OLDEST, pick_weight());
      send_beat(CMD_LARGEST, pick_weight());

      // random bursts that fill to full, drain to empty, or hover in between
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct  = 72;
            recv_stall_pct <= 34;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct <= 0;
            hold_req       <= 1'b1;
         end
         if (burst_left == 0) begin
            mode       = burst_mode_type'($urandom_range(2));
            burst_left = $urandom_range(20, 90);
         end
         burst_left--;
         case (mode)
            BURST_FILL:  arrive_pct = 90;
            BURST_DRAIN: arrive_pct = 15;
            default:     arrive_pct = 50;
         endcase
         if ($urandom_range(99) < arrive_pct) begin
            cmd = fomdq_pkg::CMD_ARRIVE;
         end else begin
            pick = $urandom_range(99);
            if (pick < 45)      cmd = fomdq_pkg::CMD_OLDEST;
            else if (pick < 80) cmd = CMD_LARGEST;
            else                cmd = CMD_LARGEST_ALT;
         end
         send_beat(cmd, pick_weight());
      end
      req_valid <= 1'b0;

      // wait out the outstanding results, then a little longer for strays
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d request beats: %0d stored, %0d served, %0d empty serves, %0d dropped full",
               req_beats, stored_seen, served_seen, empty_seen, full_seen);
      $display("Peak queue depth %0d of %0d, with sender gaps, receiver stalls and a long hold",
               peak_depth, fomdq_pkg::DEPTH);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Mismatches %0d, results still expected %0d", fail_count, pending);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/fomdq_pkg.sv
rtl/fomdq_cell.sv
rtl/fifo_or_max_dispatch_queue_core.sv
rtl/fomdq_checker.sv
dv/fomdq_checker.sv
dv/tb_fifo_or_max_dispatch_queue_core.sv
